### hw/rtl/scc_pkg.sv
package scc_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CY,
        S_CM,
        S_CD,
        S_CMUL,
        S_CSUM,
        S_DV1,
        S_DW1,
        S_DV2,
        S_DW2,
        S_DV3,
        S_DW3,
        S_DY,
        S_DM,
        S_WK,
        S_WKW,
        S_OUT
    } t_state;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_LOAD = 2'd1;
    localparam logic [1:0] FUNC_CAL  = 2'd2;

    localparam int DIVW = 17;
    localparam logic [DIVW-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [DIVW-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [DIVW-1:0] SECS_PER_MIN  = 17'd60;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2: len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] wk_offset(input logic [3:0] m);
        logic [2:0] off;
        case (m)
            4'd2: off = 3'd3;
            4'd3: off = 3'd3;
            4'd4: off = 3'd6;
            4'd5: off = 3'd1;
            4'd6: off = 3'd4;
            4'd7: off = 3'd6;
            4'd8: off = 3'd2;
            4'd9: off = 3'd5;
            4'd11: off = 3'd3;
            4'd12: off = 3'd5;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

endpackage

### hw/rtl/scc_div.sv
module scc_div #(
    parameter int W  = 32,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [W-1:0]  o_quot,
    output logic [DW-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_n;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_ge;

    assign w_sh   = {r_rem, r_q[W-1]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_n    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= CW'(W);
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_q   <= {r_q[W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
                r_n   <= r_n - 1'b1;
                if (r_n == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

### hw/rtl/scc_wkday.sv
module scc_wkday (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_ge2000,
    input  logic [6:0] i_lo,
    input  logic [3:0] i_month,
    input  logic [4:0] i_day,
    output logic       o_done,
    output logic [2:0] o_weekday
);
    import scc_pkg::*;

    logic [8:0] r_t;
    logic       r_busy;
    logic [7:0] w_lo;
    logic [8:0] w_sum;
    logic       w_adj;

    assign w_lo  = {1'b0, i_lo} + (i_ge2000 ? 8'd100 : 8'd0);
    assign w_adj = (i_lo[1:0] == 2'd0) && (i_month < 4'd3);
    assign w_sum = {1'b0, w_lo} + {3'b0, w_lo[7:2]} + {4'b0, i_day}
                 + {6'b0, wk_offset(i_month)} - {8'b0, w_adj};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_t    <= w_sum;
        end else if (r_busy) begin
            if (r_t >= 9'd7) begin
                r_t <= r_t - 9'd7;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done    = r_busy && (r_t < 9'd7);
    assign o_weekday = (r_t[2:0] == 3'd0) ? 3'd7 : r_t[2:0];
endmodule

### hw/rtl/seconds_counter_calendar.sv
// Real-time clock that keeps a 32-bit seconds count from January 1 of YEAR_BASE and answers
// every request with one result: the count, the calendar date and time, and the weekday
// (1 Monday to 7 Sunday). A tick request runs three bit-serial divisions, steps through the
// elapsed years since YEAR_BASE one at a time, then through the months, and reduces the
// weekday sum by repeated subtraction of seven. A calendar load first steps through each
// year from YEAR_BASE to the loaded year and each month, then adds the day and the time.
// One request is handled at a time; a new one is taken while the last result waits on the output.
module seconds_counter_calendar #(
    parameter int YEAR_BASE = 2000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // count_value[31:0], set_year[43:32], set_month[47:44], set_date[52:48],
    // set_hours[57:53], set_minutes[63:58], set_seconds[69:64], zero pad[71:70]
    input  logic [71:0] i_s_tdata,
    // func[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // count[31:0], year[43:32], month[47:44], date[52:48], hours[57:53],
    // minutes[63:58], seconds[69:64], weekday[72:70], zero pad[79:73]
    output logic [79:0] o_m_tdata
);
    import scc_pkg::*;

    localparam logic [11:0] BASE     = 12'(YEAR_BASE);
    localparam logic [1:0]  BASE_M4  = 2'(YEAR_BASE % 4);
    localparam logic [6:0]  BASE_M100 = 7'(YEAR_BASE % 100);
    localparam logic [8:0]  BASE_M400 = 9'(YEAR_BASE % 400);

    t_state r_state, n_state;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_prod, n_prod;
    logic [16:0] r_hms, n_hms;
    logic [11:0] r_sy, n_sy;
    logic [3:0]  r_smo, n_smo;
    logic [4:0]  r_sd, n_sd;
    logic [4:0]  r_sh, n_sh;
    logic [5:0]  r_smi, n_smi;
    logic [5:0]  r_ss, n_ss;
    logic [11:0] r_y, n_y;
    logic [1:0]  r_y4, n_y4;
    logic [6:0]  r_y100, n_y100;
    logic [8:0]  r_y400, n_y400;
    logic [3:0]  r_m, n_m;
    logic [15:0] r_days, n_days;
    logic [16:0] r_rem, n_rem;
    logic [4:0]  r_hours, n_hours;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;
    logic [2:0]  r_wk, n_wk;
    logic        r_ov, n_ov;
    logic [79:0] r_odata, n_odata;

    logic        w_accept;
    logic        w_leap;
    logic [8:0]  w_ylen;
    logic [4:0]  w_mlen;
    logic [3:0]  w_moc;
    logic        w_div_start;
    logic [31:0] w_div_a;
    logic [16:0] w_div_b;
    logic        w_div_done;
    logic [31:0] w_div_q;
    logic [16:0] w_div_r;
    logic        w_wk_start;
    logic        w_wk_done;
    logic [2:0]  w_wk;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_leap   = ((r_y4 == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);
    assign w_ylen   = w_leap ? 9'd366 : 9'd365;
    assign w_mlen   = month_len(r_m, w_leap);
    assign w_moc    = (r_smo == 4'd0) ? 4'd1 : ((r_smo > 4'd12) ? 4'd12 : r_smo);

    scc_div #(.W(32), .DW(DIVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quot     (w_div_q),
        .o_rem      (w_div_r)
    );

    scc_wkday u_wkday (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_wk_start),
        .i_ge2000  (r_y >= 12'd2000),
        .i_lo      (r_y100),
        .i_month   (r_m),
        .i_day     (r_days[4:0] + 5'd1),
        .o_done    (w_wk_done),
        .o_weekday (w_wk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_prod  <= n_prod;
        r_hms   <= n_hms;
        r_sy    <= n_sy;
        r_smo   <= n_smo;
        r_sd    <= n_sd;
        r_sh    <= n_sh;
        r_smi   <= n_smi;
        r_ss    <= n_ss;
        r_y     <= n_y;
        r_y4    <= n_y4;
        r_y100  <= n_y100;
        r_y400  <= n_y400;
        r_m     <= n_m;
        r_days  <= n_days;
        r_rem   <= n_rem;
        r_hours <= n_hours;
        r_min   <= n_min;
        r_sec   <= n_sec;
        r_wk    <= n_wk;
        r_odata <= n_odata;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_hms   = r_hms;
        n_sy    = r_sy;
        n_smo   = r_smo;
        n_sd    = r_sd;
        n_sh    = r_sh;
        n_smi   = r_smi;
        n_ss    = r_ss;
        n_y     = r_y;
        n_y4    = r_y4;
        n_y100  = r_y100;
        n_y400  = r_y400;
        n_m     = r_m;
        n_days  = r_days;
        n_rem   = r_rem;
        n_hours = r_hours;
        n_min   = r_min;
        n_sec   = r_sec;
        n_wk    = r_wk;
        n_odata = r_odata;
        n_ov    = r_ov && !i_m_tready;
        o_s_tready  = 1'b0;
        w_div_start = 1'b0;
        w_div_a     = r_cnt;
        w_div_b     = SECS_PER_DAY;
        w_wk_start  = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_sy   = i_s_tdata[43:32];
                    n_smo  = i_s_tdata[47:44];
                    n_sd   = i_s_tdata[52:48];
                    n_sh   = i_s_tdata[57:53];
                    n_smi  = i_s_tdata[63:58];
                    n_ss   = i_s_tdata[69:64];
                    n_y    = BASE;
                    n_y4   = BASE_M4;
                    n_y100 = BASE_M100;
                    n_y400 = BASE_M400;
                    n_acc  = '0;
                    n_state = S_DV1;
                    case (i_s_tuser)
                        FUNC_TICK: n_cnt = r_cnt + 32'd1;
                        FUNC_LOAD: n_cnt = i_s_tdata[31:0];
                        FUNC_CAL: begin
                            if (i_s_tdata[43:32] < BASE) begin
                                n_cnt = '0;
                            end else begin
                                n_state = S_CY;
                            end
                        end
                        default: n_cnt = r_cnt;
                    endcase
                end
            end
            S_CY: begin
                if (r_y == r_sy) begin
                    n_m     = 4'd1;
                    n_state = S_CM;
                end else begin
                    n_acc  = r_acc + {23'b0, w_ylen};
                    n_y    = r_y + 12'd1;
                    n_y4   = r_y4 + 2'd1;
                    n_y100 = (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
                    n_y400 = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                end
            end
            S_CM: begin
                if (r_m == w_moc) begin
                    n_state = S_CD;
                end else begin
                    n_acc = r_acc + {27'b0, w_mlen};
                    n_m   = r_m + 4'd1;
                end
            end
            S_CD: begin
                n_acc   = r_acc + {27'b0, r_sd} - 32'd1;
                n_state = S_CMUL;
            end
            S_CMUL: begin
                n_prod  = r_acc * {15'b0, SECS_PER_DAY};
                n_hms   = 17'(r_sh * SECS_PER_HOUR) + 17'(r_smi * SECS_PER_MIN)
                        + {11'b0, r_ss};
                n_state = S_CSUM;
            end
            S_CSUM: begin
                n_cnt   = r_prod + {15'b0, r_hms};
                n_state = S_DV1;
            end
            S_DV1: begin
                w_div_start = 1'b1;
                n_state     = S_DW1;
            end
            S_DW1: begin
                if (w_div_done) begin
                    n_days  = w_div_q[15:0];
                    n_rem   = w_div_r;
                    n_state = S_DV2;
                end
            end
            S_DV2: begin
                w_div_start = 1'b1;
                w_div_a     = {15'b0, r_rem};
                w_div_b     = SECS_PER_HOUR;
                n_state     = S_DW2;
            end
            S_DW2: begin
                if (w_div_done) begin
                    n_hours = w_div_q[4:0];
                    n_rem   = w_div_r;
                    n_state = S_DV3;
                end
            end
            S_DV3: begin
                w_div_start = 1'b1;
                w_div_a     = {15'b0, r_rem};
                w_div_b     = SECS_PER_MIN;
                n_state     = S_DW3;
            end
            S_DW3: begin
                if (w_div_done) begin
                    n_min   = w_div_q[5:0];
                    n_sec   = w_div_r[5:0];
                    n_y     = BASE;
                    n_y4    = BASE_M4;
                    n_y100  = BASE_M100;
                    n_y400  = BASE_M400;
                    n_state = S_DY;
                end
            end
            S_DY: begin
                if (r_days >= {7'b0, w_ylen}) begin
                    n_days = r_days - {7'b0, w_ylen};
                    n_y    = r_y + 12'd1;
                    n_y4   = r_y4 + 2'd1;
                    n_y100 = (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
                    n_y400 = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                end else begin
                    n_m     = 4'd1;
                    n_state = S_DM;
                end
            end
            S_DM: begin
                if ((r_days >= {11'b0, w_mlen}) && (r_m < 4'd12)) begin
                    n_days = r_days - {11'b0, w_mlen};
                    n_m    = r_m + 4'd1;
                end else begin
                    n_state = S_WK;
                end
            end
            S_WK: begin
                w_wk_start = 1'b1;
                n_state    = S_WKW;
            end
            S_WKW: begin
                if (w_wk_done) begin
                    n_wk    = w_wk;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || i_m_tready) begin
                    n_ov    = 1'b1;
                    n_odata = {7'b0, r_wk, r_sec, r_min, r_hours, r_days[4:0] + 5'd1,
                               r_m, r_y, r_cnt};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;

    a_count_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> (o_m_tdata[31:0] == r_cnt))
        else $error("result count differs from the held count");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[57:53] < 5'd24) && (o_m_tdata[63:58] < 6'd60)
                       && (o_m_tdata[69:64] < 6'd60))
        else $error("time of day out of range");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[47:44] != 4'd0) && (o_m_tdata[47:44] < 4'd13)
                       && (o_m_tdata[72:70] != 3'd0))
        else $error("month or weekday out of range");

    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_tready)
        else $error("request taken while busy");
endmodule

### verif/scc_checker.sv
`timescale 1ns / 1ps

module scc_checker #(
    parameter int YEAR_BASE = 2000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [71:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);
    import scc_pkg::*;

    logic [31:0] clock_seconds;
    logic [79:0] expected_view_q[$];
    int          mismatches = 0;

    function automatic bit is_leap(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_of_month(int unsigned y, int unsigned m);
        int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && is_leap(y)) return 29;
        return lens[(m - 1) % 12];
    endfunction

    function automatic logic [31:0] calendar_to_seconds(int unsigned y, int unsigned mo,
                                                         int unsigned d, int unsigned h,
                                                         int unsigned mi, int unsigned s);
        int unsigned acc;
        if (y < YEAR_BASE) return 32'd0;
        if (mo < 1) mo = 1;
        if (mo > 12) mo = 12;
        acc = (y - YEAR_BASE) * 365 * 86400;
        for (int unsigned i = YEAR_BASE; i < y; i++) begin
            if (is_leap(i)) acc += 86400;
        end
        for (int unsigned i = 1; i < mo; i++) begin
            acc += days_of_month(y, i) * 86400;
        end
        acc += (d - 1) * 86400;
        acc += h * 3600;
        acc += mi * 60;
        acc += s;
        return acc;
    endfunction

    function automatic int unsigned day_of_week(int unsigned y, int unsigned m, int unsigned d);
        int unsigned offs[12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
        int unsigned hi, lo, t;
        hi = y / 100;
        lo = y % 100;
        if (hi > 19) lo += 100;
        t = (lo + lo / 4) % 7;
        t = t + d + offs[(m - 1) % 12];
        if ((lo % 4 == 0) && m < 3) t--;
        t %= 7;
        return (t == 0) ? 7 : t;
    endfunction

    function automatic logic [79:0] calendar_view(logic [31:0] cnt);
        int unsigned days, rem, y, m, ylen, mlen;
        logic [79:0] v;
        days = cnt / 86400;
        rem  = cnt % 86400;
        y = YEAR_BASE;
        ylen = is_leap(y) ? 366 : 365;
        while (days >= ylen) begin
            days -= ylen;
            y++;
            ylen = is_leap(y) ? 366 : 365;
        end
        m = 1;
        mlen = days_of_month(y, m);
        while (days >= mlen && m < 12) begin
            days -= mlen;
            m++;
            mlen = days_of_month(y, m);
        end
        v = '0;
        v[31:0]  = cnt;
        v[43:32] = y[11:0];
        v[47:44] = m[3:0];
        v[52:48] = 5'(days + 1);
        v[57:53] = 5'(rem / 3600);
        v[63:58] = 6'((rem % 3600) / 60);
        v[69:64] = 6'(rem % 60);
        v[72:70] = 3'(day_of_week(y, m, days + 1));
        return v;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name,
                         exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        logic [79:0] exp_v;
        if (!i_rst_n) begin
            clock_seconds <= '0;
            expected_view_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                logic [31:0] next_count;
                case (i_s_tuser)
                    FUNC_TICK: next_count = clock_seconds + 32'd1;
                    FUNC_LOAD: next_count = i_s_tdata[31:0];
                    FUNC_CAL:  next_count = calendar_to_seconds(i_s_tdata[43:32],
                                   i_s_tdata[47:44], i_s_tdata[52:48], i_s_tdata[57:53],
                                   i_s_tdata[63:58], i_s_tdata[69:64]);
                    default:   next_count = clock_seconds;
                endcase
                clock_seconds <= next_count;
                expected_view_q.push_back(calendar_view(next_count));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_view_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result %h", $realtime, i_m_tdata);
                end else begin
                    exp_v = expected_view_q.pop_front();
                    compare_field("count",   exp_v[31:0],  i_m_tdata[31:0]);
                    compare_field("year",    exp_v[43:32], i_m_tdata[43:32]);
                    compare_field("month",   exp_v[47:44], i_m_tdata[47:44]);
                    compare_field("date",    exp_v[52:48], i_m_tdata[52:48]);
                    compare_field("hours",   exp_v[57:53], i_m_tdata[57:53]);
                    compare_field("minutes", exp_v[63:58], i_m_tdata[63:58]);
                    compare_field("seconds", exp_v[69:64], i_m_tdata[69:64]);
                    compare_field("weekday", exp_v[72:70], i_m_tdata[72:70]);
                    compare_field("pad",     exp_v[79:73], i_m_tdata[79:73]);
                end
            end
        end
    end

    assign o_fail_count = mismatches;
    assign o_pending    = expected_view_q.size();

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import scc_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int STALL_LIMIT = 50000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;
    int          fail_count;
    int          pending;
    bit          steady_sender = 0;
    bit          steady_receiver = 0;
    bit          holding_results = 0;
    int          requests_sent = 0;
    int          quiet_cycles = 0;

    seconds_counter_calendar dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata)
    );

    scc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (holding_results)
            m_tready <= 1'b0;
        else
            m_tready <= steady_receiver || ($urandom_range(99) >= 32);
    end

    // The output is held off for a long stretch while the sender keeps offering requests.
    initial begin
        wait (requests_sent >= 300);
        holding_results = 1;
        repeat (3000) @(posedge i_clk);
        holding_results = 0;
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("** seconds_counter_calendar: FAILED **");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] func, logic [71:0] data);
        while (!steady_sender && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        do @(posedge i_clk); while (!s_tready);
        requests_sent++;
    endtask

    task automatic send_calendar(int unsigned y, int unsigned mo, int unsigned d,
                                 int unsigned h, int unsigned mi, int unsigned s);
        logic [71:0] data;
        data = '0;
        data[31:0]  = $urandom();
        data[43:32] = y[11:0];
        data[47:44] = mo[3:0];
        data[52:48] = d[4:0];
        data[57:53] = h[4:0];
        data[63:58] = mi[5:0];
        data[69:64] = s[5:0];
        send_request(FUNC_CAL, data);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned pick;
        logic [71:0] data;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(FUNC_TICK, 72'd0);
        send_request(FUNC_LOAD, 72'hFFFF_FFFF);
        send_request(FUNC_TICK, 72'd0);
        send_request(FUNC_LOAD, 72'd0);
        send_calendar(1999, 12, 31, 23, 59, 59);
        send_calendar(0, 0, 0, 0, 0, 0);
        send_calendar(4095, 15, 31, 31, 63, 63);
        send_calendar(2000, 2, 29, 23, 59, 59);
        send_request(FUNC_TICK, 72'd0);
        send_calendar(2100, 2, 28, 23, 59, 59);
        send_request(FUNC_TICK, 72'd0);
        send_calendar(2024, 0, 0, 12, 30, 30);
        send_calendar(2050, 13, 15, 0, 0, 0);
        send_calendar(2096, 12, 31, 23, 59, 59);
        send_request(FUNC_TICK, 72'd0);
        send_calendar(2136, 2, 7, 6, 28, 15);
        send_request(FUNC_NONE, {40'd0, 32'h1234_5678});
        send_request(FUNC_LOAD, 72'hAAAA_AAAA);
        send_request(FUNC_LOAD, 72'h5555_5555);
        send_calendar(2400, 2, 29, 0, 0, 0);
        send_calendar(2001, 3, 1, 0, 0, 0);

        for (int i = 0; i < 1330; i++) begin
            steady_sender   = (i >= 700 && i < 850);
            steady_receiver = (i >= 700 && i < 850);
            if (i == 500) wait_for_results();
            pick = $urandom_range(99);
            if (pick < 50) begin
                send_request(FUNC_TICK, {$urandom(), $urandom(), 8'($urandom())});
            end else if (pick < 68) begin
                data = '0;
                data[31:0] = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(3)
                                                      : $urandom();
                send_request(FUNC_LOAD, data);
            end else if (pick < 90) begin
                send_calendar($urandom_range(2136, 2000), $urandom_range(12, 1),
                              $urandom_range(28, 1), $urandom_range(23), $urandom_range(59),
                              $urandom_range(59));
            end else if (pick < 95) begin
                data = '0;
                data[69:0] = {$urandom(), $urandom(), 6'($urandom())};
                if ($urandom_range(3) != 0) data[43:32] = 12'($urandom_range(2200, 1990));
                send_request(FUNC_CAL, data);
            end else begin
                send_request(FUNC_NONE, {$urandom(), $urandom(), 8'($urandom())});
            end
        end
        wait_for_results();
        repeat (400) @(posedge i_clk);
        if (fail_count == 0)
            $display("** seconds_counter_calendar: PASSED **");
        else
            $display("** seconds_counter_calendar: FAILED **");
        $finish;
    end

endmodule

### sim.f
hw/rtl/scc_pkg.sv
hw/rtl/scc_div.sv
hw/rtl/scc_wkday.sv
hw/rtl/seconds_counter_calendar.sv
verif/scc_checker.sv
verif/testbench.sv
